// ===== rtl/sle_pkg.sv =====
// shared types and command codes for the serial line editor
// front end, back end and top level use this package; no dependencies
package sle_pkg;

	typedef logic [2:0] op_t;

	localparam op_t OP_NONE   = 3'd0;
	localparam op_t OP_INSERT = 3'd1;
	localparam op_t OP_BS     = 3'd2;
	localparam op_t OP_LEFT   = 3'd3;
	localparam op_t OP_RIGHT  = 3'd4;
	localparam op_t OP_CLEAR  = 3'd5;
	localparam op_t OP_EMIT   = 3'd6;

	// one classified byte as queued between front and back
	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
	} cmd_t;

endpackage

// ===== rtl/sle_fifo.sv =====
// small register queue between the front decoder and the back executor
// generic width and depth, no package dependencies
module sle_fifo #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             push;
	logic             pop;

	assign in_ready  = (count_q != CNTW'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(DEPTH))
		else $error("queue count beyond depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CNTW'(1)))
		else $error("queue count did not grow on push");
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - CNTW'(1)))
		else $error("queue count did not shrink on pop");
`endif

endmodule

// ===== rtl/sle_front.sv =====
// front end: accepts terminal bytes, tracks escape sequences, classifies into commands
// uses sle_pkg for command codes and the queue entry type
module sle_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output sle_pkg::cmd_t cmd
);
	import sle_pkg::*;

	localparam logic [7:0]  BYTE_CTRL_A = 8'd1;
	localparam logic [7:0]  BYTE_BS     = 8'd8;
	localparam logic [7:0]  BYTE_LF     = 8'd10;
	localparam logic [7:0]  BYTE_CR     = 8'd13;
	localparam logic [7:0]  BYTE_ESC    = 8'd27;
	localparam logic [7:0]  BYTE_DEL    = 8'd127;
	localparam logic [23:0] CODE_LEFT   = 24'h1B5B44;
	localparam logic [23:0] CODE_RIGHT  = 24'h1B5B43;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_ESC   = 2'd1;
	localparam logic [1:0] PH_FINAL = 2'd2;

	logic [1:0]  phase_q;
	logic [1:0]  phase_d;
	logic [15:0] pend_q;
	logic [15:0] pend_d;
	logic        take;

	assign s_tready  = cmd_ready;
	assign cmd_valid = s_tvalid;
	assign take      = s_tvalid && cmd_ready;

	always_comb begin
		phase_d = phase_q;
		pend_d  = pend_q;
		cmd.op  = OP_NONE;
		cmd.ch  = s_tdata;
		case (phase_q)
			PH_ESC: begin
				pend_d  = {pend_q[15:8], s_tdata};
				phase_d = PH_FINAL;
			end
			PH_FINAL: begin
				phase_d = PH_IDLE;
				pend_d  = '0;
				if ({pend_q, s_tdata} == CODE_LEFT) begin
					cmd.op = OP_LEFT;
				end else if ({pend_q, s_tdata} == CODE_RIGHT) begin
					cmd.op = OP_RIGHT;
				end
			end
			default: begin
				// idle, and the unused phase code behaves as idle
				phase_d = PH_IDLE;
				if (s_tdata == BYTE_ESC) begin
					pend_d  = {BYTE_ESC, 8'h00};
					phase_d = PH_ESC;
				end else if (s_tdata == BYTE_BS) begin
					cmd.op = OP_BS;
				end else if (s_tdata == BYTE_LF) begin
					cmd.op = OP_NONE;
				end else if (s_tdata == BYTE_CR) begin
					cmd.op = OP_EMIT;
				end else if (s_tdata == BYTE_CTRL_A) begin
					cmd.op = OP_CLEAR;
				end else if (s_tdata >= BYTE_DEL) begin
					// high byte swallows the next one
					pend_d  = {8'h00, s_tdata};
					phase_d = PH_FINAL;
				end else begin
					cmd.op = OP_INSERT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pend_q  <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			pend_q  <= pend_d;
		end
	end

endmodule

// ===== rtl/sle_back.sv =====
// back end: line cell row, cursor, edit execution and result output register
// uses sle_pkg for command codes; line emission runs as a per-character sequence
module sle_back #(
	parameter int  LINE_LEN = 32,
	localparam int CW       = $clog2(LINE_LEN),
	localparam int LW       = $clog2(LINE_LEN + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  sle_pkg::cmd_t cmd,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic          kind,
	output logic [7:0]    char_out,
	output logic [CW-1:0] cursor_pos,
	output logic [LW-1:0] line_length,
	output logic          changed,
	output logic          last
);
	import sle_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RESP = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	// log-depth prefix and, bit j is the and of bits 0..j
	function automatic logic [LINE_LEN-1:0] prefix_and(input logic [LINE_LEN-1:0] v);
		logic [LINE_LEN-1:0] p;
		p = v;
		for (int s = 1; s < LINE_LEN; s = s * 2) begin
			for (int j = LINE_LEN - 1; j >= s; j--) begin
				p[j] = p[j] & p[j - s];
			end
		end
		return p;
	endfunction

	logic [7:0]          cells_q [LINE_LEN];
	logic [7:0]          cells_d [LINE_LEN];
	logic [CW-1:0]       cursor_q;
	logic [CW-1:0]       cursor_d;
	logic [1:0]          st_q;
	logic [1:0]          st_d;
	logic                pchg_q;
	logic                pchg_d;
	logic [LW-1:0]       n_q;
	logic [LW-1:0]       n_d;
	logic [LW-1:0]       cnt_q;
	logic [LW-1:0]       cnt_d;
	logic                m_tvalid_q;
	logic                kind_q;
	logic [7:0]          char_q;
	logic [CW-1:0]       curpos_q;
	logic [LW-1:0]       len_q;
	logic                chg_q;
	logic                last_q;

	logic [LINE_LEN-1:0] nz;
	logic [LINE_LEN-1:0] pall;
	logic [LINE_LEN-1:0] gate;
	logic [LINE_LEN-1:0] pbs;
	logic [LINE_LEN-1:0] run;
	logic [LW-1:0]       len_w;
	logic [CW-1:0]       cm1;
	logic                right_ok;
	logic                out_free;
	logic                ld_resp;
	logic                ld_emit;
	logic                emit_last;
	logic                pop;

	assign out_free  = !m_tvalid_q || m_tready;
	assign cmd_ready = (st_q == ST_IDLE);
	assign pop       = cmd_valid && cmd_ready;
	assign cm1       = cursor_q - CW'(1);
	assign emit_last = (cnt_q == n_q - LW'(1));

	// nonzero map, line length and backspace shift span
	always_comb begin
		for (int j = 0; j < LINE_LEN; j++) begin
			nz[j]   = (cells_q[j] != 8'h00);
			gate[j] = (CW'(j) < cm1) || nz[j];
		end
		pall  = prefix_and(nz);
		pbs   = prefix_and(gate);
		len_w = '0;
		if (pall[LINE_LEN-1]) begin
			len_w = LW'(LINE_LEN);
		end else begin
			if (!nz[0]) begin
				len_w = '0;
			end
			for (int j = 1; j < LINE_LEN; j++) begin
				if (pall[j-1] && !nz[j]) begin
					len_w = len_w | LW'(j);
				end
			end
		end
		for (int j = 0; j < LINE_LEN; j++) begin
			run[j] = (CW'(j) >= cm1) && pbs[j];
		end
	end

	assign right_ok = (cursor_q < CW'(LINE_LEN - 2)) && nz[cursor_q + CW'(1)];

	always_comb begin
		cells_d  = cells_q;
		cursor_d = cursor_q;
		st_d     = st_q;
		pchg_d   = pchg_q;
		n_d      = n_q;
		cnt_d    = cnt_q;
		ld_resp  = 1'b0;
		ld_emit  = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (pop) begin
					st_d   = ST_RESP;
					pchg_d = 1'b0;
					case (cmd.op)
						OP_INSERT: begin
							cells_d[0] = (cursor_q == '0) ? cmd.ch : cells_q[0];
							for (int j = 1; j < LINE_LEN; j++) begin
								if (CW'(j) == cursor_q) begin
									cells_d[j] = cmd.ch;
								end else if (CW'(j) > cursor_q) begin
									cells_d[j] = cells_q[j-1];
								end
							end
							if (cursor_q < CW'(LINE_LEN - 1)) begin
								cursor_d = cursor_q + CW'(1);
							end
							pchg_d = 1'b1;
						end
						OP_BS: begin
							if (cursor_q != '0) begin
								cursor_d = cm1;
								pchg_d   = 1'b1;
								for (int j = 0; j < LINE_LEN - 1; j++) begin
									if (run[j]) begin
										cells_d[j] = cells_q[j+1];
									end
								end
								if (run[LINE_LEN-2]) begin
									cells_d[LINE_LEN-1] = 8'h00;
								end
							end
						end
						OP_LEFT: begin
							if (cursor_q != '0) begin
								cursor_d = cm1;
								pchg_d   = 1'b1;
							end
						end
						OP_RIGHT: begin
							if (right_ok) begin
								cursor_d = cursor_q + CW'(1);
								pchg_d   = 1'b1;
							end
						end
						OP_CLEAR: begin
							for (int j = 0; j < LINE_LEN; j++) begin
								cells_d[j] = 8'h00;
							end
							cursor_d = '0;
							pchg_d   = 1'b1;
						end
						OP_EMIT: begin
							cursor_d = '0;
							if (len_w == '0) begin
								// empty line: clear, no result
								for (int j = 0; j < LINE_LEN; j++) begin
									cells_d[j] = 8'h00;
								end
								st_d = ST_IDLE;
							end else begin
								n_d   = len_w;
								cnt_d = '0;
								st_d  = ST_EMIT;
							end
						end
						default: begin
							pchg_d = 1'b0;
						end
					endcase
				end
			end
			ST_RESP: begin
				if (out_free) begin
					ld_resp = 1'b1;
					st_d    = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					ld_emit = 1'b1;
					cnt_d   = cnt_q + LW'(1);
					if (emit_last) begin
						for (int j = 0; j < LINE_LEN; j++) begin
							cells_d[j] = 8'h00;
						end
						st_d = ST_IDLE;
					end else begin
						for (int j = 0; j < LINE_LEN - 1; j++) begin
							cells_d[j] = cells_q[j+1];
						end
						cells_d[LINE_LEN-1] = 8'h00;
					end
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < LINE_LEN; j++) begin
				cells_q[j] <= 8'h00;
			end
			cursor_q   <= '0;
			st_q       <= ST_IDLE;
			pchg_q     <= 1'b0;
			n_q        <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			cells_q  <= cells_d;
			cursor_q <= cursor_d;
			st_q     <= st_d;
			pchg_q   <= pchg_d;
			n_q      <= n_d;
			cnt_q    <= cnt_d;
			if (ld_resp || ld_emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_resp) begin
			kind_q   <= 1'b0;
			char_q   <= 8'h00;
			curpos_q <= cursor_q;
			len_q    <= len_w;
			chg_q    <= pchg_q;
			last_q   <= 1'b1;
		end else if (ld_emit) begin
			kind_q   <= 1'b1;
			char_q   <= cells_q[0];
			curpos_q <= '0;
			len_q    <= '0;
			chg_q    <= 1'b1;
			last_q   <= emit_last;
		end
	end

	assign m_tvalid    = m_tvalid_q;
	assign kind        = kind_q;
	assign char_out    = char_q;
	assign cursor_pos  = curpos_q;
	assign line_length = len_q;
	assign changed     = chg_q;
	assign last        = last_q;

`ifndef ASSERT_OFF
	a_cursor_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= CW'(LINE_LEN - 1))
		else $error("cursor beyond last cell");
	a_emit_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && kind_q) |-> (curpos_q == '0 && len_q == '0 && chg_q))
		else $error("line character result without cleared state");
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !kind_q) |-> last_q)
		else $error("status result not marked last");
	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT) |-> (n_q != '0 && cnt_q < n_q && cursor_q == '0))
		else $error("emission counter out of range");
`endif

endmodule

// ===== rtl/serial_line_editor_top.sv =====
// serial line editor top level: byte decoder, command queue and line executor
// depends on sle_pkg, sle_front, sle_fifo and sle_back
//
//  channel  | direction | signals                           | payload
//  ---------+-----------+-----------------------------------+---------------------------------
//  s_*      | in        | s_tvalid s_tready s_tdata         | terminal byte
//  m_*      | out       | m_tvalid m_tready m_tdata m_tuser | status or line character result
//           |           | m_tlast                           | final result of one input byte
//
// flow: an input byte is taken whenever the command queue has room;
// the back end applies an edit byte, then loads the result register once it is free,
// and on a carriage return with an n character line loads one result per character
// reset: line cells all zero, cursor at zero, escape decoder idle, queue empty
// stalls: m_tready low holds the result register; the queue of QUEUE_DEPTH commands
// keeps s_tready high meanwhile until it fills
module serial_line_editor_top #(
	parameter int  LINE_LEN    = 32,
	parameter int  QUEUE_DEPTH = 4,
	localparam int CW          = $clog2(LINE_LEN),
	localparam int LW          = $clog2(LINE_LEN + 1),
	localparam int RAW_W       = 8 + CW + LW + 1,
	localparam int DATA_W      = ((RAW_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // byte_in
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // char_out, cursor_pos, line_length, changed, zero pad
	output logic              m_tuser,   // kind
	output logic              m_tlast
);
	import sle_pkg::*;

	// classified command from the decoder into the queue
	cmd_t          fr_cmd;
	logic          fr_valid;
	logic          fr_ready;
	// queue head into the executor
	cmd_t          bk_cmd;
	logic          bk_valid;
	logic          bk_ready;

	// result fields from the executor's output register
	logic [7:0]    res_char;
	logic [CW-1:0] res_cursor;
	logic [LW-1:0] res_len;
	logic          res_chg;

	sle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cmd_valid (fr_valid),
		.cmd_ready (fr_ready),
		.cmd       (fr_cmd)
	);

	sle_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_data   (fr_cmd),
		.out_valid (bk_valid),
		.out_ready (bk_ready),
		.out_data  (bk_cmd)
	);

	sle_back #(
		.LINE_LEN (LINE_LEN)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (bk_valid),
		.cmd_ready   (bk_ready),
		.cmd         (bk_cmd),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.kind        (m_tuser),
		.char_out    (res_char),
		.cursor_pos  (res_cursor),
		.line_length (res_len),
		.changed     (res_chg),
		.last        (m_tlast)
	);

	// pack from the lowest bit up, zero filled to whole bytes
	assign m_tdata = DATA_W'({res_chg, res_len, res_cursor, res_char});

endmodule

// ===== test/sle_tb_pkg.sv =====
// terminal key codes and cursor escape sequences shared by the line editor testbench
// used by sle_checker and tb_serial_line_editor_top; no dependencies
package sle_tb_pkg;

	localparam logic [7:0] KEY_CTRL_A = 8'd1;
	localparam logic [7:0] KEY_BS     = 8'd8;
	localparam logic [7:0] KEY_LF     = 8'd10;
	localparam logic [7:0] KEY_CR     = 8'd13;
	localparam logic [7:0] KEY_ESC    = 8'd27;
	localparam logic [7:0] KEY_DEL    = 8'd127;
	localparam logic [7:0] KEY_CSI    = 8'h5B;   // '[' after escape
	localparam logic [7:0] KEY_LEFT   = 8'h44;   // 'D'
	localparam logic [7:0] KEY_RIGHT  = 8'h43;   // 'C'

	localparam logic [23:0] SEQ_LEFT  = {KEY_ESC, KEY_CSI, KEY_LEFT};
	localparam logic [23:0] SEQ_RIGHT = {KEY_ESC, KEY_CSI, KEY_RIGHT};

endpackage

// ===== test/sle_checker.sv =====
// line editor checker: tracks the line buffer, cursor and escape decoder from
// accepted input bytes and compares every result transaction; depends on sle_tb_pkg
module sle_checker #(
	parameter int LINE_LEN = 32,
	parameter int DATA_W   = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [DATA_W-1:0] m_tdata,
	input  logic              m_tuser,
	input  logic              m_tlast,
	output int                fail_count,
	output int                pending_count
);
	import sle_tb_pkg::*;

	localparam int CW = $clog2(LINE_LEN);
	localparam int LW = $clog2(LINE_LEN + 1);

	typedef enum logic [1:0] {ESC_IDLE, ESC_OPEN, ESC_FINAL, ESC_SPARE} esc_state_t;

	typedef struct packed {
		logic          kind;
		logic [7:0]    ch;
		logic [CW-1:0] cur;
		logic [LW-1:0] len;
		logic          chg;
		logic          last;
	} edit_result_t;

	logic [7:0]   cells [LINE_LEN];
	int unsigned  cursor;
	esc_state_t   esc_state;
	logic [23:0]  esc_code;
	edit_result_t result_q [$];

	function automatic int unsigned line_length();
		int unsigned n;
		n = 0;
		while (n < LINE_LEN && cells[n] != 8'h00)
			n++;
		return n;
	endfunction

	task automatic clear_line();
		for (int i = 0; i < LINE_LEN; i++)
			cells[i] = 8'h00;
		cursor = 0;
	endtask

	// applies one key to the line copy and queues the results it should produce
	task automatic apply_key(input logic [7:0] key);
		int unsigned  n;
		int unsigned  i;
		logic         chg;
		logic [7:0]   saved [LINE_LEN];
		edit_result_t r;
		chg = 1'b0;
		case (esc_state)
			ESC_OPEN: begin
				esc_code  = esc_code | {8'h00, key, 8'h00};
				esc_state = ESC_FINAL;
			end
			ESC_FINAL: begin
				esc_code  = esc_code | {16'h0000, key};
				esc_state = ESC_IDLE;
				if (esc_code == SEQ_LEFT) begin
					if (cursor > 0) begin
						cursor--;
						chg = 1'b1;
					end
				end else if (esc_code == SEQ_RIGHT) begin
					if (cursor + 2 < LINE_LEN && cells[cursor + 1] != 8'h00) begin
						cursor++;
						chg = 1'b1;
					end
				end
				esc_code = 24'h0;
			end
			default: begin
				esc_state = ESC_IDLE;
				if (key == KEY_ESC) begin
					esc_code  = {KEY_ESC, 16'h0000};
					esc_state = ESC_OPEN;
				end else if (key == KEY_BS) begin
					if (cursor > 0) begin
						cursor--;
						chg = 1'b1;
						i = cursor;
						while (i < LINE_LEN - 1 && cells[i] != 8'h00) begin
							cells[i] = cells[i + 1];
							i++;
						end
						if (i >= LINE_LEN - 1)
							cells[LINE_LEN - 1] = 8'h00;
					end
				end else if (key == KEY_LF) begin
					// no effect, status only
				end else if (key == KEY_CR) begin
					n = line_length();
					for (i = 0; i < n; i++)
						saved[i] = cells[i];
					clear_line();
					for (i = 0; i < n; i++) begin
						r.kind = 1'b1;
						r.ch   = saved[i];
						r.cur  = '0;
						r.len  = '0;
						r.chg  = 1'b1;
						r.last = (i + 1 == n);
						result_q.push_back(r);
					end
					return;
				end else if (key == KEY_CTRL_A) begin
					clear_line();
					chg = 1'b1;
				end else if (key >= KEY_DEL) begin
					// swallows the next byte
					esc_code  = {8'h00, key, 8'h00};
					esc_state = ESC_FINAL;
				end else begin
					for (i = LINE_LEN - 1; i > cursor; i--)
						cells[i] = cells[i - 1];
					cells[cursor] = key;
					if (cursor < LINE_LEN - 1)
						cursor++;
					chg = 1'b1;
				end
			end
		endcase
		r.kind = 1'b0;
		r.ch   = 8'h00;
		r.cur  = cursor[CW-1:0];
		r.len  = LW'(line_length());
		r.chg  = chg;
		r.last = 1'b1;
		result_q.push_back(r);
	endtask

	function automatic int field_error(input string name, input int want, input int got);
		if (want == got)
			return 0;
		$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		edit_result_t want;
		int           errs;
		if (!arst_n) begin
			clear_line();
			esc_state = ESC_IDLE;
			esc_code  = 24'h0;
			result_q.delete();
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			errs = 0;
			if (s_tvalid && s_tready)
				apply_key(s_tdata);
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result, expected none actual tdata %h tuser %b tlast %b",
						$time, m_tdata, m_tuser, m_tlast);
					errs++;
				end else begin
					want = result_q.pop_front();
					errs += field_error("kind", want.kind, m_tuser);
					errs += field_error("char_out", want.ch, m_tdata[7:0]);
					errs += field_error("cursor_pos", want.cur, m_tdata[8 +: CW]);
					errs += field_error("line_length", want.len, m_tdata[8 + CW +: LW]);
					errs += field_error("changed", want.chg, m_tdata[8 + CW + LW]);
					errs += field_error("last", want.last, m_tlast);
				end
			end
			fail_count    <= fail_count + errs;
			pending_count <= result_q.size();
		end
	end

endmodule

// ===== test/tb_serial_line_editor_top.sv =====
// testbench top for serial_line_editor_top: clock, reset, key stimulus and verdict
// depends on sle_tb_pkg, sle_checker and the editor rtl with sle_pkg
module tb_serial_line_editor_top;
	import sle_tb_pkg::*;

	localparam int LINE_LEN    = 32;
	localparam int RAW_W       = 8 + $clog2(LINE_LEN) + $clog2(LINE_LEN + 1) + 1;
	localparam int DATA_W      = ((RAW_W + 7) / 8) * 8;
	localparam int RANDOM_KEYS = 185;
	localparam int HOLD_CYCLES = 80;     // long receiver hold-off to fill the queue
	localparam int DRAIN_WAIT  = 40;     // covers the back end latency after the last result
	localparam int CYCLE_LIMIT = 200000;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata  = 8'h00;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic              m_tuser;
	logic              m_tlast;

	int fail_count;
	int pending_count;

	// stimulus knobs
	bit idle_on  = 1'b1;   // random gaps and stalls allowed
	bit hold_go  = 1'b0;   // starts the long receiver hold-off
	bit hold_off = 1'b0;
	int stall_left = 0;
	int keys_sent  = 0;
	int cycle_count = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	serial_line_editor_top #(
		.LINE_LEN(LINE_LEN)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	sle_checker #(
		.LINE_LEN (LINE_LEN),
		.DATA_W   (DATA_W)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// result side: random stall bursts, or the long hold-off
	always @(posedge clk) begin
		if (hold_off) begin
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 6);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// long hold-off, counted here while the sender keeps offering keys
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("serial_line_editor_top verification failed");
			$finish;
		end
	end

	// one key transaction; called at a rising edge, returns at the edge it was taken
	task automatic send_key(input logic [7:0] key);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= key;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		keys_sent++;
	endtask

	task automatic send_seq(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
		send_key(a);
		send_key(b);
		send_key(c);
	endtask

	// mostly ordinary characters, now and then any byte below delete
	function automatic logic [7:0] pick_char();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 126));
		return 8'($urandom_range(32, 126));
	endfunction

	initial begin
		int kind_sel;
		int burst;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: character extremes, cursor moves, swallowing, emit and clear
		send_key(8'h41);
		send_key(8'h7E);
		send_key(8'h20);
		send_seq(KEY_ESC, KEY_CSI, KEY_LEFT);
		send_seq(KEY_ESC, KEY_CSI, KEY_RIGHT);
		send_key(KEY_BS);
		send_seq(KEY_ESC, KEY_CSI, 8'h58);        // unknown sequence, no effect
		send_key(8'hFF);                          // swallows the next byte
		send_key(8'h41);
		send_key(KEY_DEL);                        // swallows a carriage return
		send_key(KEY_CR);
		send_key(KEY_LF);
		send_key(KEY_CR);                         // nonempty line goes out
		send_key(KEY_CR);                         // empty line, no result
		send_key(8'h02);                          // other control byte is inserted
		send_key(8'h00);                          // zero cell inserted
		send_key(KEY_BS);                         // backspace over a zero cell
		send_key(KEY_CTRL_A);

		// queue fill: hold the result side while keys keep coming
		hold_go = 1'b1;
		for (int k = 0; k < 10; k++)
			send_key(pick_char());

		// random part, mostly well formed edits
		keys_sent = 0;
		while (keys_sent < RANDOM_KEYS) begin
			// gaps on an early stretch and a middle one, none at the end
			idle_on = (keys_sent < 70) || (keys_sent >= 100 && keys_sent < 140);
			kind_sel = $urandom_range(0, 99);
			if (kind_sel < 40) begin
				send_key(pick_char());
			end else if (kind_sel < 50) begin
				send_key(KEY_BS);
			end else if (kind_sel < 62) begin
				send_seq(KEY_ESC, KEY_CSI, $urandom_range(0, 1) ? KEY_LEFT : KEY_RIGHT);
			end else if (kind_sel < 66) begin
				send_seq(KEY_ESC, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			end else if (kind_sel < 70) begin
				send_key(8'($urandom_range(127, 255)));
				send_key(8'($urandom_range(0, 255)));
			end else if (kind_sel < 78) begin
				send_key(KEY_CR);
			end else if (kind_sel < 81) begin
				send_key(KEY_CTRL_A);
			end else if (kind_sel < 84) begin
				send_key(KEY_LF);
			end else if (kind_sel < 93) begin
				send_key(8'($urandom_range(0, 255)));
			end else begin
				// run up to or past a full line, then edit near the end and emit it
				burst = $urandom_range(30, 36);
				for (int k = 0; k < burst; k++)
					send_key(pick_char());
				if ($urandom_range(0, 1))
					send_seq(KEY_ESC, KEY_CSI, KEY_LEFT);
				send_key(KEY_BS);
				send_key(KEY_BS);
				send_seq(KEY_ESC, KEY_CSI, KEY_RIGHT);
				send_key(KEY_CR);
			end
		end
		s_tvalid <= 1'b0;

		// drain: every expected result in, then a quiet stretch
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (fail_count == 0 && pending_count == 0) begin
			$display("serial_line_editor_top verification clean");
		end else begin
			$display("serial_line_editor_top verification failed");
		end
		$finish;
	end

endmodule
